// ===== rtl/core/abwsc_pkg.sv =====
// shared types and constants for the age based write stream classifier
package abwsc_pkg;

   localparam int TIME_W  = 48;
   localparam int GRAN_W  = 32;
   localparam int SUM_W   = 52;
   localparam int SID_W   = 5;
   localparam int CNT_W   = 5;
   localparam int COLLECT_W = 4;

   // request kinds
   localparam logic [1:0] KIND_CLASSIFY = 2'd0;
   localparam logic [1:0] KIND_COLLECT  = 2'd1;
   localparam logic [1:0] KIND_VICTIM   = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   // register indexes
   localparam logic [1:0] REG_STREAM_COUNT = 2'd0;
   localparam logic [1:0] REG_GRANULARITY  = 2'd1;
   localparam logic [1:0] REG_CREATED_MODE = 2'd2;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

// ===== rtl/core/abwsc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module abwsc_div
   import abwsc_pkg::*;
#(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output div_ctl_type      ctl,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CW-1:0]    n_ff, n_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   shifted;

   // load the operands on start, else shift in one numerator bit and try a subtract
   always_comb begin
      shifted = {r_ff, q_ff[NUM_W-1]};
      trial   = shifted - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         q_in    = numer;
         r_in    = '0;
         d_in    = denom;
         n_in    = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W]) begin
            r_in = trial[DEN_W-1:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = shifted[DEN_W-1:0];
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      n_ff <= n_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quot      = q_ff;
   assign rem       = r_ff;

endmodule

// ===== rtl/core/age_based_write_stream_classifier.sv =====
// top level of the age based write stream classifier
// responses are registered: host classify and empty victim requests answer on accept, a
// victim pop from the pop state, gc in age mode when the divide by granularity is done, gc in
// creation time mode from the update state after two divides; one request at a time, busy
// until the done state returns to idle; receiver cannot stall; reset is synchronous, restores
// register defaults, clears average, collect sum, seen bits and victim count
module age_based_write_stream_classifier
   import abwsc_pkg::*;
#(
   parameter int MAX_STREAM_COUNT = 16,
   parameter int GC_BASE          = 2,
   parameter int VICTIM_DEPTH     = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic              req_is_gc,
   input  logic [TIME_W-1:0] req_now_time,
   input  logic [TIME_W-1:0] req_created_time,
   input  logic              req_segment_class_zero,
   output logic              rsp_strobe,
   output logic [SID_W-1:0]  rsp_stream_sel,
   output logic              rsp_victim_valid,
   output logic              rsp_victim_dropped,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [GRAN_W-1:0] csr_data
);

   localparam int SW = (MAX_STREAM_COUNT > 1) ? $clog2(MAX_STREAM_COUNT) : 1;
   localparam int VW = (VICTIM_DEPTH > 1) ? $clog2(VICTIM_DEPTH) : 1;
   localparam int VCW = $clog2(VICTIM_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV1, ST_DIV2, ST_UPDATE, ST_POP, ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [CNT_W-1:0]  cnt_ff;
   logic [GRAN_W-1:0] gran_ff;
   logic              mode_ff;

   // classifier state
   logic [SUM_W-1:0]     avg_total_ff;
   logic                 avg_valid_ff;
   logic [SUM_W-1:0]     collect_sum_ff;
   logic [COLLECT_W-1:0] collect_count_ff;
   logic [TIME_W-1:0]    cycle_mem [MAX_STREAM_COUNT];
   logic [MAX_STREAM_COUNT-1:0] seen_ff;
   logic [SW-1:0]        victim_mem [VICTIM_DEPTH];
   logic [VCW-1:0]       vcount_ff;
   logic [SW-1:0]        pop_ff;

   // request hold
   logic [TIME_W-1:0] age_ff;
   logic [TIME_W-1:0] cycle_rd_ff;
   logic [SW-1:0]     sid_ff;

   logic [TIME_W-1:0] age_w;
   logic [CNT_W-1:0]  n_act;
   logic [GRAN_W-1:0] g_act;
   logic              div_start;
   logic [TIME_W-1:0] div_num;
   logic [GRAN_W-1:0] div_den;
   div_ctl_type       div_ctl;
   logic [TIME_W-1:0] div_q;
   logic [GRAN_W-1:0] div_r;
   logic [SUM_W-1:0]  age16;
   logic [SUM_W-1:0]  sum_next;

   assign age_w = req_now_time - req_created_time;
   assign n_act = (cnt_ff == '0) ? CNT_W'(1)
                : (int'(cnt_ff) > MAX_STREAM_COUNT) ? CNT_W'(MAX_STREAM_COUNT) : cnt_ff;
   assign g_act = (gran_ff == '0) ? GRAN_W'(1) : gran_ff;
   assign age16 = {age_w, 4'b0000};
   assign sum_next = collect_sum_ff + SUM_W'(age_w);

   assign csr_ready = (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);

   abwsc_div #(.NUM_W(TIME_W), .DEN_W(GRAN_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_num), .denom(div_den),
      .ctl(div_ctl), .quot(div_q), .rem(div_r)
   );

   // divider feeds: first by granularity, then (creation time mode only) quotient by stream count
   always_comb begin
      div_start = 1'b0;
      div_num   = mode_ff ? req_created_time : age_w;
      div_den   = g_act;
      if (state_ff == ST_IDLE) begin
         div_start = start && req_kind == KIND_CLASSIFY && req_is_gc;
      end else if (state_ff == ST_DIV1 && div_ctl.done && mode_ff) begin
         div_start = 1'b1;
         div_num   = div_q;
         div_den   = GRAN_W'(n_act);
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV2 && div_ctl.done) begin
         cycle_rd_ff <= cycle_mem[div_r[SW-1:0]];
      end
      if (state_ff == ST_UPDATE && (!seen_ff[sid_ff] || age_ff > cycle_rd_ff)) begin
         cycle_mem[sid_ff] <= age_ff;
      end
      if (state_ff == ST_UPDATE && seen_ff[sid_ff] && age_ff > cycle_rd_ff
          && vcount_ff < VCW'(VICTIM_DEPTH)) begin
         victim_mem[vcount_ff[VW-1:0]] <= sid_ff;
      end
      if (state_ff == ST_IDLE && start && vcount_ff != '0) begin
         pop_ff <= victim_mem[VW'(vcount_ff - 1'b1)];
      end
   end

   // control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         cnt_ff             <= CNT_W'(4);
         gran_ff            <= GRAN_W'(1);
         mode_ff            <= 1'b0;
         avg_total_ff       <= '0;
         avg_valid_ff       <= 1'b0;
         collect_sum_ff     <= '0;
         collect_count_ff   <= '0;
         seen_ff            <= '0;
         vcount_ff          <= '0;
         rsp_strobe         <= 1'b0;
         rsp_stream_sel     <= '0;
         rsp_victim_valid   <= 1'b0;
         rsp_victim_dropped <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  case (csr_index)
                     REG_STREAM_COUNT: cnt_ff  <= csr_data[CNT_W-1:0];
                     REG_GRANULARITY:  gran_ff <= csr_data;
                     REG_CREATED_MODE: mode_ff <= csr_data[0];
                     default: ;
                  endcase
               end
               if (start) begin
                  age_ff <= age_w;
                  case (req_kind)
                     KIND_CLASSIFY: begin
                        if (req_is_gc) begin
                           state_ff <= ST_DIV1;
                        end else begin
                           rsp_strobe     <= 1'b1;
                           rsp_stream_sel <= (age_w != '0 &&
                              (!avg_valid_ff || age16 < avg_total_ff)) ? '0 : SID_W'(1);
                           rsp_victim_valid   <= 1'b0;
                           rsp_victim_dropped <= 1'b0;
                           state_ff <= ST_DONE;
                        end
                     end
                     KIND_COLLECT: begin
                        if (req_segment_class_zero) begin
                           if (collect_count_ff == '1) begin
                              avg_total_ff     <= sum_next;
                              avg_valid_ff     <= 1'b1;
                              collect_sum_ff   <= '0;
                              collect_count_ff <= '0;
                           end else begin
                              collect_sum_ff   <= sum_next;
                              collect_count_ff <= collect_count_ff + 1'b1;
                           end
                        end
                        state_ff <= ST_DONE;
                     end
                     KIND_VICTIM: begin
                        if (mode_ff && vcount_ff != '0) begin
                           vcount_ff <= vcount_ff - 1'b1;
                           state_ff  <= ST_POP;
                        end else begin
                           rsp_strobe         <= 1'b1;
                           rsp_stream_sel     <= '0;
                           rsp_victim_valid   <= 1'b0;
                           rsp_victim_dropped <= 1'b0;
                           state_ff           <= ST_DONE;
                        end
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_DIV1: begin
               if (div_ctl.done) begin
                  if (mode_ff) begin
                     state_ff <= ST_DIV2;
                  end else begin
                     rsp_strobe <= 1'b1;
                     rsp_stream_sel <= (div_q >= TIME_W'(n_act))
                        ? SID_W'(n_act - 1'b1 + CNT_W'(GC_BASE))
                        : SID_W'(div_q[CNT_W-1:0] + CNT_W'(GC_BASE));
                     rsp_victim_valid   <= 1'b0;
                     rsp_victim_dropped <= 1'b0;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DIV2: begin
               if (div_ctl.done) begin
                  sid_ff   <= div_r[SW-1:0];
                  age_ff   <= div_q;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               rsp_strobe         <= 1'b1;
               rsp_stream_sel     <= SID_W'(32'(sid_ff) + GC_BASE);
               rsp_victim_valid   <= 1'b0;
               rsp_victim_dropped <= 1'b0;
               if (!seen_ff[sid_ff]) begin
                  seen_ff[sid_ff] <= 1'b1;
               end else if (age_ff > cycle_rd_ff) begin
                  if (vcount_ff < VCW'(VICTIM_DEPTH)) begin
                     vcount_ff <= vcount_ff + 1'b1;
                  end else begin
                     rsp_victim_dropped <= 1'b1;
                  end
               end
               state_ff <= ST_DONE;
            end
            ST_POP: begin
               rsp_strobe         <= 1'b1;
               rsp_stream_sel     <= SID_W'(32'(pop_ff) + GC_BASE);
               rsp_victim_valid   <= 1'b1;
               rsp_victim_dropped <= 1'b0;
               state_ff           <= ST_DONE;
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= VCW'(VICTIM_DEPTH)) else $error("victim count overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |=> rsp_strobe && rsp_victim_valid) else $error("pop lost");
   a_pop_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_victim_valid |-> !rsp_victim_dropped)
      else $error("popped victim flagged as dropped");
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double response");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_ctl.busy) else $error("divider busy while idle");

endmodule

// ===== verif/age_based_write_stream_classifier_tb.sv =====
// testbench for the age based write stream classifier: driver, monitor and placement predictor
`timescale 1ns / 1ps

module age_based_write_stream_classifier_tb
   import abwsc_pkg::*;
();

   localparam int STREAM_SLOTS = 16;
   localparam int BASE_SID     = 2;
   localparam int STACK_DEPTH  = 32;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_WAIT   = 150;

   typedef struct packed {
      logic [1:0]        kind;
      logic              is_gc;
      logic [TIME_W-1:0] now_time;
      logic [TIME_W-1:0] created_time;
      logic              class_zero;
   } request_type;

   typedef struct packed {
      logic [SID_W-1:0] stream_sel;
      logic             victim_valid;
      logic             victim_dropped;
   } placement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = '0;
   logic req_is_gc = 1'b0;
   logic [TIME_W-1:0] req_now_time = '0;
   logic [TIME_W-1:0] req_created_time = '0;
   logic req_segment_class_zero = 1'b0;
   logic rsp_strobe;
   logic [SID_W-1:0] rsp_stream_sel;
   logic rsp_victim_valid;
   logic rsp_victim_dropped;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [GRAN_W-1:0] csr_data = '0;

   age_based_write_stream_classifier dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // pending requests and expected placements
   request_type   pending_reqs[$];
   placement_type expected_placements[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  hold_sender = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;

   // predictor state
   logic [4:0]        cfg_count;
   logic [31:0]       cfg_gran;
   logic              cfg_created;
   logic [SUM_W-1:0]  lifespan_avg;
   logic              lifespan_avg_ok;
   logic [SUM_W-1:0]  lifespan_sum;
   logic [3:0]        lifespan_n;
   logic [TIME_W-1:0] cycle_of[STREAM_SLOTS];
   logic              seen_of[STREAM_SLOTS];
   logic [3:0]        victims[STACK_DEPTH];
   int                victim_depth;

   // queue helpers
   function automatic void queue_req(input request_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic void add_expected(input placement_type p);
      expected_placements.insert(expected_placements.size(), p);
   endfunction

   function automatic void place_request(input request_type r);
      logic [TIME_W-1:0] age;
      logic [63:0] n, g, q, cyc, sid;
      placement_type p;
      age = r.now_time - r.created_time;
      p = '0;
      if (r.kind == KIND_CLASSIFY) begin
         if (!r.is_gc) begin
            p.stream_sel = (age != 0 && (!lifespan_avg_ok ||
               ({4'd0, age} << 4) < lifespan_avg)) ? 5'd0 : 5'd1;
         end else begin
            n = (cfg_count == 0) ? 1 : (cfg_count > STREAM_SLOTS ? STREAM_SLOTS : cfg_count);
            g = (cfg_gran == 0) ? 1 : cfg_gran;
            q = (cfg_created ? {16'd0, r.created_time} : {16'd0, age}) / g;
            if (cfg_created) begin
               cyc = q / n;
               sid = q % n;
               if (!seen_of[sid]) begin
                  seen_of[sid] = 1'b1;
                  cycle_of[sid] = cyc[TIME_W-1:0];
               end else if (cyc > cycle_of[sid]) begin
                  if (victim_depth < STACK_DEPTH) begin
                     victims[victim_depth] = sid[3:0];
                     victim_depth++;
                  end else begin
                     p.victim_dropped = 1'b1;
                  end
                  cycle_of[sid] = cyc[TIME_W-1:0];
               end
            end else begin
               sid = (q >= n) ? n - 1 : q;
            end
            p.stream_sel = SID_W'(sid + BASE_SID);
         end
         add_expected(p);
      end else if (r.kind == KIND_COLLECT) begin
         if (r.class_zero) begin
            lifespan_sum = lifespan_sum + age;
            lifespan_n = lifespan_n + 4'd1;
            if (lifespan_n == 0) begin
               lifespan_avg = lifespan_sum;
               lifespan_avg_ok = 1'b1;
               lifespan_sum = '0;
            end
         end
      end else if (r.kind == KIND_VICTIM) begin
         if (cfg_created && victim_depth > 0) begin
            victim_depth--;
            p.stream_sel = SID_W'(victims[victim_depth] + BASE_SID);
            p.victim_valid = 1'b1;
         end
         add_expected(p);
      end
   endfunction

   // driver: bursts and gaps, one request at a time
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         place_request({req_kind, req_is_gc, req_now_time, req_created_time,
            req_segment_class_zero});
         if (burst_left > 0 && pending_reqs.size() > 0 && !hold_sender) begin
            request_type r;
            r = pending_reqs.pop_front();
            {req_kind, req_is_gc, req_now_time, req_created_time,
               req_segment_class_zero} <= r;
            burst_left <= burst_left - 1;
         end else begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() > 0 && !hold_sender) begin
            request_type r;
            r = pending_reqs.pop_front();
            {req_kind, req_is_gc, req_now_time, req_created_time,
               req_segment_class_zero} <= r;
            start <= 1'b1;
            burst_left <= $urandom_range(0, 12);
         end
      end
   end

   // monitor: compare each response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         placement_type got, want;
         got = {rsp_stream_sel, rsp_victim_valid, rsp_victim_dropped};
         if (expected_placements.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = expected_placements.pop_front();
            if (got.stream_sel !== want.stream_sel) begin
               $display("%0t: stream expected %0d actual %0d", $time,
                  want.stream_sel, got.stream_sel);
               fail_count++;
            end
            if (got.victim_valid !== want.victim_valid) begin
               $display("%0t: victim_valid expected %0d actual %0d", $time,
                  want.victim_valid, got.victim_valid);
               fail_count++;
            end
            if (got.victim_dropped !== want.victim_dropped) begin
               $display("%0t: victim_dropped expected %0d actual %0d", $time,
                  want.victim_dropped, got.victim_dropped);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted request, register write or response
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_STREAM_COUNT) cfg_count = value[4:0];
      else if (idx == REG_GRANULARITY) cfg_gran = value;
      else if (idx == REG_CREATED_MODE) cfg_created = value[0];
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || start || expected_placements.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic request_type make_req(input logic [1:0] kind, input logic gc,
      input logic [47:0] now_t, input logic [47:0] made, input logic c0);
      request_type r;
      r.kind = kind;
      r.is_gc = gc;
      r.now_time = now_t;
      r.created_time = made;
      r.class_zero = c0;
      return r;
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   // random request mix for one phase
   task automatic fill_random(input int count);
      request_type r;
      logic [47:0] base;
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         base = (cfg_created && $urandom_range(0, 3) != 0) ?
            {40'd0, 8'($urandom_range(0, 255))} : rand48();
         r = make_req(KIND_CLASSIFY, 1'($urandom_range(0, 1)), rand48(), rand48(),
            1'($urandom_range(0, 1)));
         if ($urandom_range(0, 2) == 0) r.now_time = r.created_time + $urandom_range(0, 4000);
         if (sel < 45) begin
            r.is_gc = 1'b1;
            if (cfg_created) r.created_time = base * (cfg_gran == 0 ? 1 : cfg_gran) +
               $urandom_range(0, 3);
         end else if (sel < 65) begin
            r.is_gc = 1'b0;
         end else if (sel < 82) begin
            r.kind = KIND_COLLECT;
            r.class_zero = $urandom_range(0, 4) != 0;
         end else if (sel < 97) begin
            r.kind = KIND_VICTIM;
         end else begin
            r.kind = KIND_RESERVED;
         end
         queue_req(r);
      end
   endtask

   initial begin
      cfg_count = 5'd4;
      cfg_gran = 32'd1;
      cfg_created = 1'b0;
      lifespan_avg = '0;
      lifespan_avg_ok = 1'b0;
      lifespan_sum = '0;
      lifespan_n = '0;
      victim_depth = 0;
      for (int i = 0; i < STREAM_SLOTS; i++) seen_of[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, extremes, host before and after the average exists
      queue_req(make_req(KIND_CLASSIFY, 1'b0, 48'd5, 48'd5, 1'b0));
      queue_req(make_req(KIND_CLASSIFY, 1'b0, 48'd3, 48'hFFFF_FFFF_FFFF, 1'b1));
      queue_req(make_req(KIND_CLASSIFY, 1'b1, 48'hFFFF_FFFF_FFFF, 48'd0, 1'b1));
      queue_req(make_req(KIND_CLASSIFY, 1'b1, 48'd2, 48'd0, 1'b0));
      queue_req(make_req(KIND_VICTIM, 1'b1, 48'd0, 48'd0, 1'b0));
      queue_req(make_req(KIND_RESERVED, 1'b1, 48'hFFFF_FFFF_FFFF, 48'd7, 1'b1));
      queue_req(make_req(KIND_COLLECT, 1'b0, 48'd100, 48'd0, 1'b0));
      for (int i = 0; i < 16; i++)
         queue_req(make_req(KIND_COLLECT, 1'b0, 48'd100 + i, 48'd0, 1'b1));
      queue_req(make_req(KIND_CLASSIFY, 1'b0, 48'd50, 48'd0, 1'b0));
      queue_req(make_req(KIND_CLASSIFY, 1'b0, 48'd200, 48'd0, 1'b0));
      wait_idle();

      // creation time mode, zero granularity and zero count, wrap then pops
      write_reg(REG_CREATED_MODE, 32'd1);
      write_reg(REG_GRANULARITY, 32'd0);
      write_reg(REG_STREAM_COUNT, 32'd0);
      queue_req(make_req(KIND_CLASSIFY, 1'b1, 48'd0, 48'd4, 1'b0));
      queue_req(make_req(KIND_CLASSIFY, 1'b1, 48'd0, 48'd9, 1'b0));
      queue_req(make_req(KIND_CLASSIFY, 1'b1, 48'd0, 48'd2, 1'b0));
      queue_req(make_req(KIND_VICTIM, 1'b0, 48'd0, 48'd0, 1'b0));
      queue_req(make_req(KIND_VICTIM, 1'b0, 48'd0, 48'd0, 1'b0));
      wait_idle();

      // fill the stack past full with one stream, count above the maximum
      write_reg(REG_STREAM_COUNT, 32'd31);
      write_reg(REG_GRANULARITY, 32'hFFFF_FFFF);
      for (int i = 0; i < 48; i++)
         queue_req(make_req(KIND_CLASSIFY, 1'b1, 48'd0,
            48'(64'(i + 1) * 64'h1_0000_0000 * 16), 1'b0));
      fill_random(150);
      wait_idle();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_STREAM_COUNT, 32'($urandom_range(0, 31)));
         case (ph % 3)
            0: write_reg(REG_GRANULARITY, $urandom_range(1, 16));
            1: write_reg(REG_GRANULARITY, 32'hFFFF_FFFF);
            default: write_reg(REG_GRANULARITY, $urandom());
         endcase
         write_reg(REG_CREATED_MODE, ph[0] ? 32'd0 : 32'd1);
         fill_random(80);
         // sender holds off until every response is in
         while (pending_reqs.size() > 40) @(posedge clock);
         hold_sender = 1'b1;
         while (start || expected_placements.size() > 0) @(posedge clock);
         repeat ($urandom_range(1, 20)) @(posedge clock);
         hold_sender = 1'b0;
         fill_random(70);
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
